/* rtl/htbp_pkg.sv */
// shared types and constants for the huffman table bit packer
// no dependencies; compiled first
package htbp_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int SYMBOL_W = 9;
   localparam int LENGTH_W = 5;
   localparam int CODE_W   = 16;
   localparam int BYTE_W   = 8;

   // code table
   localparam int MAX_CODE_BITS     = 16;
   localparam int TERMINATOR_SYMBOL = 256;
   localparam int TABLE_DEPTH       = 257;
   localparam int ENTRY_W           = LENGTH_W + CODE_W;

   // packing datapath
   localparam int PEND_W     = 3;
   localparam int OUT_BYTES  = 3;
   localparam int STREAM_W   = OUT_BYTES * BYTE_W;
   localparam int TOTAL_W    = 6;
   localparam int COUNT_W    = 2;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   // result of merging one code into the partial byte
   typedef struct packed {
      logic [COUNT_W-1:0]                count;
      logic                              last;
      logic [OUT_BYTES-1:0][BYTE_W-1:0]  bytes;
      logic [BYTE_W-1:0]                 acc;
      logic [PEND_W-1:0]                 pending;
   } pack_type;

endpackage

/* rtl/htbp_if.sv */
// request and response channel interfaces of the huffman table bit packer
// depends on htbp_pkg
interface htbp_req_if;
   import htbp_pkg::*;

   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     operation;
   logic [SYMBOL_W-1:0] symbol_index;
   logic [LENGTH_W-1:0] code_length;
   logic [CODE_W-1:0]   code_bits;
   logic [BYTE_W-1:0]   data_byte;

   modport source (output valid, operation, symbol_index, code_length, code_bits, data_byte,
                   input ready);
   modport sink (input valid, operation, symbol_index, code_length, code_bits, data_byte,
                 output ready);
endinterface

interface htbp_rsp_if;
   import htbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] packed_byte;
   logic              last_byte;

   modport source (output valid, packed_byte, last_byte, input ready);
   modport sink (input valid, packed_byte, last_byte, output ready);
endinterface

/* rtl/huffman_table_bit_packer.sv */
// top level of the static huffman encoder with terminator symbol
// depends on htbp_pkg, htbp_if (htbp_req_if, htbp_rsp_if) and htbp_ram
//
//   channel   direction  handshake          payload
//   req_chan  in         valid / ready      operation, symbol_index, code_length,
//                                           code_bits, data_byte
//   rsp_chan  out        valid / ready      packed_byte, last_byte
//
// a request reads the code table in its accept cycle; the registered table entry is then
// merged into the partial byte and up to three bytes go into the output buffer
// bytes leave one per cycle while the response channel is ready
// requests follow back to back while the output buffer drains its last byte
// the table has no reset; an entry must be loaded before it is used
// reset clears the partial byte, the pipeline stage and the output buffer
module huffman_table_bit_packer (
   input logic       clock,
   input logic       reset,
   htbp_req_if.sink  req_chan,
   htbp_rsp_if.source rsp_chan
);
   import htbp_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic                req_fire;
   logic                rsp_fire;
   logic                advance;
   logic                load_ok;

   logic                s1_valid_ff, s1_valid_in;
   logic [OP_W-1:0]     s1_op_ff, s1_op_in;

   logic [BYTE_W-1:0]   acc_ff, acc_in;
   logic [PEND_W-1:0]   pend_ff, pend_in;

   logic [BYTE_W-1:0]   buf_byte_ff [OUT_BYTES];
   logic [BYTE_W-1:0]   buf_byte_in [OUT_BYTES];
   logic [COUNT_W-1:0]  buf_count_ff, buf_count_in;
   logic                buf_last_ff, buf_last_in;

   logic                ram_we;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [LENGTH_W-1:0] len_sat;

   pack_type            pk;

   // handshakes
   assign rsp_fire       = rsp_chan.valid & rsp_chan.ready;
   assign req_fire       = req_chan.valid & req_chan.ready;
   assign advance        = s1_valid_ff & load_ok;
   assign req_chan.ready = ~s1_valid_ff | advance;

   // table access in the accept cycle
   always_comb begin
      len_sat = (req_chan.code_length > LENGTH_W'(MAX_CODE_BITS)) ?
                LENGTH_W'(MAX_CODE_BITS) : req_chan.code_length;
      ram_we      = req_fire && (op_type'(req_chan.operation) == OP_LOAD) &&
                    (req_chan.symbol_index < SYMBOL_W'(TABLE_DEPTH));
      ram_wr_addr = ADDR_W'(req_chan.symbol_index);
      ram_wr_data = {len_sat, req_chan.code_bits};
      ram_re      = req_fire;
      ram_rd_addr = (op_type'(req_chan.operation) == OP_FINISH) ?
                    ADDR_W'(TERMINATOR_SYMBOL) : ADDR_W'(req_chan.data_byte);
   end

   htbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // merge the table code into the partial byte
   always_comb begin
      logic [LENGTH_W-1:0] len;
      logic [CODE_W-1:0]   code;
      logic [CODE_W-1:0]   mask;
      logic [STREAM_W-1:0] stream;
      logic [STREAM_W-1:0] aligned;
      logic [TOTAL_W-1:0]  total;
      logic [TOTAL_W-1:0]  nbytes;
      logic [PEND_W-1:0]   rem;
      logic                is_finish;

      len       = ram_rd_data[ENTRY_W-1:CODE_W];
      code      = ram_rd_data[CODE_W-1:0];
      mask      = CODE_W'((17'd1 << len) - 17'd1);
      stream    = (STREAM_W'(acc_ff) << len) | STREAM_W'(code & mask);
      total     = TOTAL_W'(pend_ff) + TOTAL_W'(len);
      aligned   = stream << (TOTAL_W'(STREAM_W) - total);
      nbytes    = total >> 3;
      rem       = total[PEND_W-1:0];
      is_finish = (op_type'(s1_op_ff) == OP_FINISH);

      pk.bytes[0] = aligned[STREAM_W-1 -: BYTE_W];
      pk.bytes[1] = aligned[STREAM_W-BYTE_W-1 -: BYTE_W];
      pk.bytes[2] = aligned[BYTE_W-1:0];

      case (op_type'(s1_op_ff))
         OP_ENCODE, OP_FINISH: begin
            pk.count   = COUNT_W'(nbytes) + COUNT_W'(is_finish && (rem != '0));
            pk.last    = is_finish;
            pk.acc     = is_finish ? '0 : (stream[BYTE_W-1:0] & BYTE_W'((9'd1 << rem) - 9'd1));
            pk.pending = is_finish ? '0 : rem;
         end
         default: begin
            pk.count   = '0;
            pk.last    = 1'b0;
            pk.acc     = acc_ff;
            pk.pending = pend_ff;
         end
      endcase
   end

   // buffer takes the merge result when empty or emptying, or when the merge yields no bytes
   assign load_ok = (buf_count_ff == '0) || ((buf_count_ff == COUNT_W'(1)) && rsp_fire) ||
                    (pk.count == '0);

   // next state of pipeline stage, partial byte and output buffer
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_op_in    = req_chan.operation;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end

      acc_in  = advance ? pk.acc : acc_ff;
      pend_in = advance ? pk.pending : pend_ff;

      buf_byte_in  = buf_byte_ff;
      buf_count_in = buf_count_ff;
      buf_last_in  = buf_last_ff;
      if (rsp_fire) begin
         for (int i = 0; i < OUT_BYTES - 1; i++) begin
            buf_byte_in[i] = buf_byte_ff[i+1];
         end
         buf_count_in = buf_count_ff - COUNT_W'(1);
      end
      if (advance && (pk.count != '0)) begin
         for (int i = 0; i < OUT_BYTES; i++) begin
            buf_byte_in[i] = pk.bytes[i];
         end
         buf_count_in = pk.count;
         buf_last_in  = pk.last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         pend_ff      <= '0;
         buf_count_ff <= '0;
         buf_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         buf_count_ff <= buf_count_in;
         buf_last_ff  <= buf_last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_op_ff    <= s1_op_in;
      buf_byte_ff <= buf_byte_in;
   end

   // response outputs
   assign rsp_chan.valid       = (buf_count_ff != '0);
   assign rsp_chan.packed_byte = buf_byte_ff[0];
   assign rsp_chan.last_byte   = buf_last_ff && (buf_count_ff == COUNT_W'(1));

endmodule

/* rtl/htbp_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
module htbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/htbp_checker.sv */
// port level checks for the huffman table bit packer, bound to the top level
// depends on htbp_pkg and huffman_table_bit_packer
module htbp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [htbp_pkg::OP_W-1:0]     req_operation,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [htbp_pkg::BYTE_W-1:0]   rsp_packed_byte,
   input logic                          rsp_last_byte
);
   import htbp_pkg::*;

   // a stalled response holds its byte
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_packed_byte) &&
                                  $stable(rsp_last_byte))
      else $error("response changed while stalled");

   // requests only back up behind pending output bytes
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no output pending");

   // output starts only from an accepted encode or finish request, after its table read and pipeline stage
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2) &&
                           ($past(req_operation, 2) != OP_LOAD))
      else $error("response without a producing request");

endmodule

bind huffman_table_bit_packer htbp_checker u_htbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_operation   (req_chan.operation),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_packed_byte (rsp_chan.packed_byte),
   .rsp_last_byte   (rsp_chan.last_byte)
);
